[hw/rtl/dpms_pkg.sv]
// Package for the drive profile master sequencer: payload structs, step and
// phase encodings, control and status word constants, saturation helpers.
// Depends on nothing; imported by drive_profile_master_sequencer_core.
`default_nettype none

package dpms_pkg;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_POSITION_OFFSET = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_NODE_INDEX      = 2'd1;

  localparam logic [3:0] REQ_CYCLE       = 4'd0;
  localparam logic [3:0] REQ_ENABLE      = 4'd1;
  localparam logic [3:0] REQ_CLEAR_FAULT = 4'd2;
  localparam logic [3:0] REQ_DISABLE     = 4'd3;
  localparam logic [3:0] REQ_TOGGLE_HALT = 4'd4;
  localparam logic [3:0] REQ_HOME        = 4'd5;
  localparam logic [3:0] REQ_TARGET_POS  = 4'd6;
  localparam logic [3:0] REQ_POS_VEL     = 4'd7;
  localparam logic [3:0] REQ_START_POS   = 4'd8;
  localparam logic [3:0] REQ_END_VEL     = 4'd9;
  localparam logic [3:0] REQ_VELOCITY    = 4'd10;

  localparam logic [15:0] SW_STATE_MASK      = 16'h006F;
  localparam logic [15:0] SW_READY_TO_SWITCH = 16'h0021;
  localparam logic [15:0] SW_SWITCHED_ON     = 16'h0023;
  localparam logic [15:0] SW_OP_ENABLED      = 16'h0027;
  localparam logic [15:0] SW_FAULT_ACK       = 16'h0080;
  localparam logic [15:0] SW_TARGET_REACHED  = 16'h0400;
  localparam logic [15:0] SW_SP_ACK          = 16'h1000;

  localparam logic [15:0] CW_SHUTDOWN     = 16'h0006;
  localparam logic [15:0] CW_SWITCH_ON    = 16'h0007;
  localparam logic [15:0] CW_ENABLE_OP    = 16'h000F;
  localparam logic [15:0] CW_NEW_SP       = 16'h0010;
  localparam logic [15:0] CW_IMMEDIATE    = 16'h0020;
  localparam logic [15:0] CW_FAULT_RESET  = 16'h0080;
  localparam logic [15:0] CW_HALT         = 16'h0100;

  localparam logic signed [7:0] MODE_POSITION = 8'sd1;
  localparam logic signed [7:0] MODE_VELOCITY = 8'sd3;
  localparam logic signed [7:0] MODE_HOMING   = 8'sd6;

  localparam logic [14:0] HOME_OFFSET_STEP = 15'd100;

  localparam logic signed [31:0] INT32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] INT32_MIN = 32'sh8000_0000;

  typedef enum logic [2:0] {
    ST_NONE       = 3'd0,
    ST_T2         = 3'd1,
    ST_T3         = 3'd2,
    ST_T4         = 3'd3,
    ST_T14        = 3'd4,
    ST_T15        = 3'd5,
    ST_HOME_START = 3'd6,
    ST_HOME_WAIT  = 3'd7
  } step_t;

  typedef enum logic [2:0] {
    PH_NONE      = 3'd0,
    PH_ENABLING  = 3'd1,
    PH_MODE      = 3'd2,
    PH_CLEAR_ACK = 3'd3,
    PH_ACK       = 3'd4
  } phase_t;

  typedef struct packed {
    logic enabling;
    logic enabled;
    logic change_req;
    logic positioning;
    logic homing;
    logic disabling;
    logic clearing;
  } flags_t;

  typedef struct packed {
    step_t       step;
    logic [15:0] cw;
    logic        done;
  } fault_res_t;

  typedef struct packed {
    logic [3:0]         req_type;
    logic [15:0]        status_word;
    logic [7:0]         drive_error;
    logic signed [7:0]  mode_display;
    logic signed [31:0] cmd_value;
    logic signed [31:0] velocity_correction;
  } item_t;

  typedef struct packed {
    logic [15:0]        control_word;
    logic signed [7:0]  mode_request;
    logic signed [31:0] target_velocity_out;
    logic signed [31:0] target_position_out;
    logic [31:0]        profile_velocity_out;
    logic [31:0]        end_velocity_out;
    logic [14:0]        home_offset_out;
    logic               homing_method_write;
    logic               is_enabled;
    logic               target_reached;
    logic signed [31:0] reported_velocity;
  } result_t;

  function automatic logic signed [31:0] sat_s33(logic signed [32:0] v);
    logic signed [31:0] r;
    if (v[32] != v[31]) begin
      r = v[32] ? INT32_MIN : INT32_MAX;
    end else begin
      r = $signed(v[31:0]);
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat_s38(logic signed [37:0] v);
    logic signed [31:0] r;
    if (v[37:31] != {7{v[31]}}) begin
      r = v[37] ? INT32_MIN : INT32_MAX;
    end else begin
      r = $signed(v[31:0]);
    end
    return r;
  endfunction

  function automatic fault_res_t fault_steps(step_t step, logic [15:0] cw,
                                             logic [15:0] sw);
    fault_res_t r;
    r.step = step;
    r.cw   = cw;
    r.done = 1'b0;
    if (step == ST_T14) begin
      r.cw   = cw | CW_FAULT_RESET;
      r.step = ST_T15;
    end else if (step == ST_T15) begin
      if ((sw & SW_FAULT_ACK) != 16'd0) begin
        r.cw   = cw & ~CW_FAULT_RESET;
        r.step = ST_NONE;
        r.done = 1'b1;
      end else begin
        r.cw = cw | CW_FAULT_RESET;
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/drive_profile_master_sequencer_core.sv]
// Drive profile master sequencer: the whole sequencer in one module.
// Depends on dpms_pkg for payload structs, encodings and saturation helpers.
//
// Usage: items enter on item/item_valid/item_ready, one beat per process-data
// cycle or command, and every item gives exactly one result beat on
// result/result_valid/result_ready. Configuration registers are written on
// cfg_index/cfg_data/cfg_valid with cfg_ready always high; index 0 is the
// position offset, index 1 the node index, other indices are ignored.
// Configuration must be written only while no item is in flight; the block
// itself does not enforce this. While result beats are taken, an item can be
// accepted in every cycle: each item updates the sequencer state in one
// pass through the logic between the input register and the result register.
// When the receiver stalls the result register holds its beat and the input
// register still takes one more beat; only then does item_ready fall, and it
// rises again in the cycle the result beat is taken.
// The synchronous reset empties both registers and returns all sequencer
// state and configuration registers to zero.
`default_nettype none

module drive_profile_master_sequencer_core
  import dpms_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire item_t                  item,
  input  wire logic                   item_valid,
  output logic                        item_ready,
  output result_t                     result,
  output logic                        result_valid,
  input  wire logic                   result_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready
);

  logic signed [31:0] position_offset;
  logic [7:0]         node_index;

  logic  s1_valid;
  item_t s1_item;
  logic  adv;

  step_t              pending_step, pending_step_next;
  phase_t             position_phase, position_phase_next;
  flags_t             flags, flags_next;
  logic signed [31:0] own_velocity, own_velocity_next;
  logic signed [31:0] position_copy, position_copy_next;
  logic [31:0]        speed_copy, speed_copy_next;
  logic [15:0]        control_reg, control_reg_next;
  logic signed [7:0]  mode_reg, mode_reg_next;
  logic signed [31:0] sp_tvel, sp_tvel_next;
  logic signed [31:0] sp_tpos, sp_tpos_next;
  logic [31:0]        sp_pvel, sp_pvel_next;
  logic [31:0]        sp_evel, sp_evel_next;
  logic [14:0]        sp_hoff, sp_hoff_next;
  logic               home_write;
  fault_res_t         fr;
  result_t            result_next;

  logic [15:0]        sw;
  logic signed [7:0]  md;
  logic signed [37:0] vel_scaled;

  assign cfg_ready  = 1'b1;
  assign adv        = s1_valid && (!result_valid || result_ready);
  assign item_ready = !s1_valid || adv;

  assign sw = s1_item.status_word;
  assign md = s1_item.mode_display;
  // Sixty times the command value as a shift-and-subtract.
  assign vel_scaled = (38'(s1_item.cmd_value) <<< 6) - (38'(s1_item.cmd_value) <<< 2);

  always_ff @(posedge clk) begin
    if (rst) begin
      position_offset <= '0;
      node_index      <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_POSITION_OFFSET: position_offset <= $signed(cfg_data);
        REG_NODE_INDEX:      node_index      <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_ready) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      s1_item <= item;
    end
  end

  // Next state of the sequencer for the item held in the input register.
  always_comb begin
    pending_step_next   = pending_step;
    position_phase_next = position_phase;
    flags_next          = flags;
    own_velocity_next   = own_velocity;
    position_copy_next  = position_copy;
    speed_copy_next     = speed_copy;
    control_reg_next    = control_reg;
    mode_reg_next       = mode_reg;
    sp_tvel_next        = sp_tvel;
    sp_tpos_next        = sp_tpos;
    sp_pvel_next        = sp_pvel;
    sp_evel_next        = sp_evel;
    sp_hoff_next        = sp_hoff;
    home_write          = 1'b0;
    fr                  = '0;

    unique case (s1_item.req_type)
      REQ_CYCLE: begin
        if (flags.disabling) begin
          control_reg_next    = '0;
          flags_next.enabled  = 1'b0;
          flags_next.enabling = 1'b0;
          pending_step_next   = ST_NONE;
          own_velocity_next   = '0;
        end else if (s1_item.drive_error != 8'd0) begin
          fr                = fault_steps(pending_step, control_reg, sw);
          pending_step_next = fr.step;
          control_reg_next  = fr.cw;
          if (fr.done) begin
            flags_next.clearing = 1'b0;
          end
        end else begin
          if (flags.change_req && !flags.positioning) begin
            flags_next.change_req = 1'b0;
            if (!flags.enabled) begin
              pending_step_next   = ST_T2;
              flags_next.enabling = 1'b1;
            end
            mode_reg_next          = MODE_POSITION;
            control_reg_next       = control_reg_next & ~CW_HALT;
            flags_next.positioning = 1'b1;
            position_phase_next    = PH_ENABLING;
          end
          unique case (pending_step_next) inside
            ST_T2: begin
              control_reg_next  = CW_SHUTDOWN;
              pending_step_next = ST_T3;
            end
            ST_T3: begin
              if ((sw & SW_STATE_MASK) == SW_READY_TO_SWITCH) begin
                control_reg_next  = CW_SWITCH_ON;
                pending_step_next = ST_T4;
              end
            end
            ST_T4: begin
              if ((sw & SW_STATE_MASK) == SW_SWITCHED_ON) begin
                control_reg_next  = CW_ENABLE_OP;
                pending_step_next = ST_NONE;
              end
            end
            ST_T14, ST_T15: begin
              fr                = fault_steps(pending_step_next, control_reg_next, sw);
              pending_step_next = fr.step;
              control_reg_next  = fr.cw;
              if (fr.done) begin
                flags_next.clearing = 1'b0;
              end
            end
            ST_HOME_START: begin
              if (md == MODE_HOMING) begin
                control_reg_next  = control_reg_next | CW_NEW_SP;
                pending_step_next = ST_HOME_WAIT;
              end
            end
            ST_HOME_WAIT: begin
              if ((sw & SW_SP_ACK) != 16'd0) begin
                flags_next.homing = 1'b0;
                pending_step_next = ST_NONE;
                mode_reg_next     = MODE_VELOCITY;
              end
            end
            default: ;
          endcase
          if ((sw & SW_STATE_MASK) == SW_OP_ENABLED) begin
            flags_next.enabled  = 1'b1;
            flags_next.enabling = 1'b0;
          end
          if (flags_next.enabled && flags_next.homing && pending_step_next == ST_NONE) begin
            pending_step_next = ST_HOME_START;
            home_write        = 1'b1;
            mode_reg_next     = MODE_HOMING;
          end
          if (md == MODE_VELOCITY) begin
            sp_tvel_next = sat_s33(33'(own_velocity) + 33'(s1_item.velocity_correction));
          end
          if (flags_next.positioning && flags_next.enabled) begin
            sp_tpos_next = position_copy;
            sp_pvel_next = speed_copy;
            unique case (position_phase_next)
              PH_ENABLING: begin
                if (md == MODE_POSITION) begin
                  position_phase_next = PH_MODE;
                end else begin
                  mode_reg_next = MODE_POSITION;
                end
              end
              PH_MODE: begin
                control_reg_next    = control_reg_next & ~CW_NEW_SP;
                position_phase_next = PH_CLEAR_ACK;
              end
              PH_CLEAR_ACK: begin
                if ((sw & SW_SP_ACK) == 16'd0) begin
                  control_reg_next    = control_reg_next | CW_NEW_SP | CW_IMMEDIATE;
                  position_phase_next = PH_ACK;
                end
              end
              PH_ACK: begin
                if ((sw & SW_SP_ACK) != 16'd0) begin
                  control_reg_next       = control_reg_next & ~(CW_NEW_SP | CW_IMMEDIATE);
                  position_phase_next    = PH_NONE;
                  flags_next.positioning = 1'b0;
                end
              end
              default: ;
            endcase
          end
        end
      end
      REQ_ENABLE: begin
        if (!flags.enabling) begin
          if ((sw & SW_STATE_MASK) != SW_OP_ENABLED) begin
            flags_next.enabled = 1'b0;
          end
          if (!flags_next.enabled) begin
            flags_next.enabling = 1'b1;
            pending_step_next   = ST_T2;
            mode_reg_next       = MODE_VELOCITY;
          end
        end
      end
      REQ_CLEAR_FAULT: begin
        if (!flags.clearing && pending_step == ST_NONE &&
            (s1_item.drive_error != 8'd0 || (sw & SW_FAULT_ACK) != 16'd0)) begin
          flags_next.clearing = 1'b1;
          pending_step_next   = ST_T14;
        end
      end
      REQ_DISABLE: begin
        flags_next.disabling = 1'b1;
        if (flags.enabled) begin
          control_reg_next    = '0;
          flags_next.enabled  = 1'b0;
          flags_next.enabling = 1'b0;
          pending_step_next   = ST_NONE;
          own_velocity_next   = '0;
        end
      end
      REQ_TOGGLE_HALT: begin
        control_reg_next = control_reg ^ CW_HALT;
      end
      REQ_HOME: begin
        flags_next.homing = 1'b1;
        mode_reg_next     = MODE_POSITION;
        pending_step_next = ST_T2;
        sp_hoff_next      = 15'((15'(node_index) + 15'd1) * HOME_OFFSET_STEP);
        sp_tpos_next      = '0;
      end
      REQ_TARGET_POS: begin
        position_copy_next = sat_s33(33'(s1_item.cmd_value) - 33'(position_offset));
      end
      REQ_POS_VEL: begin
        speed_copy_next = s1_item.cmd_value;
      end
      REQ_START_POS: begin
        flags_next.change_req = 1'b1;
      end
      REQ_END_VEL: begin
        control_reg_next = control_reg & ~CW_NEW_SP;
        sp_evel_next     = s1_item.cmd_value;
      end
      REQ_VELOCITY: begin
        own_velocity_next = sat_s38(vel_scaled);
      end
      default: ;
    endcase
  end

  // Result beat built from the updated state.
  always_comb begin
    result_next.control_word         = control_reg_next;
    result_next.mode_request         = mode_reg_next;
    result_next.target_velocity_out  = sp_tvel_next;
    result_next.target_position_out  = sp_tpos_next;
    result_next.profile_velocity_out = sp_pvel_next;
    result_next.end_velocity_out     = sp_evel_next;
    result_next.home_offset_out      = sp_hoff_next;
    result_next.homing_method_write  = home_write;
    result_next.is_enabled           = flags_next.enabled;
    result_next.target_reached       = !flags_next.positioning && md == MODE_POSITION &&
                                       (sw & SW_TARGET_REACHED) != 16'd0;
    result_next.reported_velocity    = ((control_reg_next & CW_HALT) != 16'd0) ?
                                       32'sd0 : own_velocity_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_step   <= ST_NONE;
      position_phase <= PH_NONE;
      flags          <= '0;
      own_velocity   <= '0;
      position_copy  <= '0;
      speed_copy     <= '0;
      control_reg    <= '0;
      mode_reg       <= '0;
      sp_tvel        <= '0;
      sp_tpos        <= '0;
      sp_pvel        <= '0;
      sp_evel        <= '0;
      sp_hoff        <= '0;
    end else if (adv) begin
      pending_step   <= pending_step_next;
      position_phase <= position_phase_next;
      flags          <= flags_next;
      own_velocity   <= own_velocity_next;
      position_copy  <= position_copy_next;
      speed_copy     <= speed_copy_next;
      control_reg    <= control_reg_next;
      mode_reg       <= mode_reg_next;
      sp_tvel        <= sp_tvel_next;
      sp_tpos        <= sp_tpos_next;
      sp_pvel        <= sp_pvel_next;
      sp_evel        <= sp_evel_next;
      sp_hoff        <= sp_hoff_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result <= result_next;
    end
  end

  // Once a disable command has been taken, nothing but reset releases it.
  a_disable_latched: assert property (@(posedge clk) disable iff (rst)
    flags.disabling |=> flags.disabling)
    else $error("disable latch released");

  // The fault acknowledge steps are only ever entered through a clear request.
  a_clearing_steps: assert property (@(posedge clk) disable iff (rst)
    (pending_step == ST_T14 || pending_step == ST_T15) |-> flags.clearing)
    else $error("fault acknowledge step without clearing flag");

  // A result beat with the halt bit set reports zero velocity.
  a_halt_velocity: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (result.control_word & CW_HALT) != 16'd0) |->
      result.reported_velocity == 32'sd0)
    else $error("velocity reported while halted");

  // A held input beat is neither lost nor altered while the result side stalls.
  a_input_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !adv) |=> (s1_valid && $stable(s1_item)))
    else $error("input register changed while stalled");

endmodule

`default_nettype wire
